[src/ffcrc_pkg.sv]
// shared types, constants and crc function for the delimited frame checker
package ffcrc_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'hFF;
	localparam logic [7:0]  ESC_BYTE  = 8'hFE;
	localparam logic [7:0]  ESC_ZERO  = 8'h00;
	localparam logic [7:0]  ESC_ONE   = 8'h01;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [8:0]  COUNT_MAX = 9'd511;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_LEN_ERR = 2'd3
	} kind_t;

	// per-frame body tracking state
	typedef struct packed {
		logic [8:0]  count;
		logic [7:0]  len;
		logic [15:0] crc;
		logic [15:0] rx_crc;
	} body_state_t;

	// decoded unstuffing result for one raw byte
	typedef struct packed {
		logic       close;
		logic       esc_next;
		logic       take0;
		logic [7:0] byte0;
		logic       take1;
		logic [7:0] byte1;
	} unstuff_t;

	// reflected crc-16, one byte, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/ffcrc_unstuff.sv]
// byte unstuffing decoder: turns one raw byte into zero, one or two body bytes
module ffcrc_unstuff (
	input  logic                escape,
	input  logic [7:0]          raw,
	output ffcrc_pkg::unstuff_t us
);

	always_comb begin
		us.close    = 1'b0;
		us.esc_next = 1'b0;
		us.take0    = 1'b0;
		us.byte0    = ffcrc_pkg::ESC_BYTE;
		us.take1    = 1'b0;
		us.byte1    = raw;
		if (raw == ffcrc_pkg::FLAG_BYTE) begin
			// pending escape at close is a literal 0xfe
			us.close = 1'b1;
			us.take0 = escape;
		end else if (escape) begin
			us.take0 = 1'b1;
			case (raw)
				ffcrc_pkg::ESC_ZERO: us.byte0 = ffcrc_pkg::ESC_BYTE;
				ffcrc_pkg::ESC_ONE:  us.byte0 = ffcrc_pkg::FLAG_BYTE;
				ffcrc_pkg::ESC_BYTE: us.esc_next = 1'b1;
				default:             us.take1 = 1'b1;
			endcase
		end else if (raw == ffcrc_pkg::ESC_BYTE) begin
			us.esc_next = 1'b1;
		end else begin
			us.take0 = 1'b1;
			us.byte0 = raw;
		end
	end

endmodule

[src/ffcrc_body.sv]
// one body byte step: count, length capture, crc update, received crc capture
module ffcrc_body (
	input  ffcrc_pkg::body_state_t st,
	input  logic                   take,
	input  logic [7:0]             b,
	output ffcrc_pkg::body_state_t st_next,
	output logic                   emit
);

	logic [8:0] lenp2;

	assign lenp2 = {1'b0, st.len} + 9'd2;

	always_comb begin
		st_next = st;
		emit    = 1'b0;
		if (take) begin
			if (st.count != ffcrc_pkg::COUNT_MAX) begin
				st_next.count = st.count + 9'd1;
			end
			if (st.count < lenp2) begin
				if (st.count == 9'd1) begin
					st_next.len = b;
				end
				st_next.crc = ffcrc_pkg::crc16_byte(st.crc, b);
				emit        = 1'b1;
			end else if (st.count == lenp2) begin
				st_next.rx_crc[15:8] = b;
			end else if (st.count == lenp2 + 9'd1) begin
				st_next.rx_crc[7:0] = b;
			end
		end
	end

endmodule

[src/ff_delimited_frame_crc_checker_top.sv]
// top level of the 0xff delimited, byte stuffed frame checker with crc-16
//
// channel  | handshake           | payload
// rx       | rx_valid, rx_ready   | rx_byte
// res      | res_valid, res_ready | data_byte, kind, payload_count, frame_end
//
// one raw byte per cycle unless res stalls: input register, unstuff/crc logic, result register
// res_valid is registered behind the input register; two chained crc byte steps set the path
// a literal escape yields two payload bytes, the second goes out with the next non-flag raw byte
// arst_n clears all frame state; no clearing pass
// a stall on res holds the result register and backs up into rx_ready
module ff_delimited_frame_crc_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] data_byte,
	output logic [1:0] kind,
	output logic [8:0] payload_count,
	output logic       frame_end
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   in_frame_q, prev_ff_q, esc_q, hold_valid_q;
	logic [7:0]             hold_byte_q;
	ffcrc_pkg::body_state_t st_q;
	logic                   res_valid_q;
	logic [7:0]             data_q;
	ffcrc_pkg::kind_t       kind_q;
	logic [8:0]             count_q;
	logic                   end_q;

	logic                   advance, step, is_flag, opening, active, esc_cur, hold_cur, close;
	ffcrc_pkg::body_state_t base_st, st0, st1;
	ffcrc_pkg::unstuff_t    us;
	logic                   emit0, emit1, n_any, n_two, emit_any;
	logic [7:0]             item0, item1;
	logic [8:0]             lenp2, lenp4, end_count;
	ffcrc_pkg::kind_t       end_kind;
	logic [7:0]             res_data;
	ffcrc_pkg::kind_t       res_kind;

	assign advance  = !res_valid_q || res_ready;
	assign rx_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	assign is_flag  = (byte_s1 == ffcrc_pkg::FLAG_BYTE);
	assign opening  = !in_frame_q && !is_flag && prev_ff_q;
	assign active   = in_frame_q || opening;
	assign esc_cur  = opening ? 1'b0 : esc_q;
	assign hold_cur = opening ? 1'b0 : hold_valid_q;
	assign base_st  = opening ? '0 : st_q;
	assign close    = active && us.close;

	ffcrc_unstuff u_unstuff (
		.escape (esc_cur),
		.raw    (byte_s1),
		.us     (us)
	);

	ffcrc_body u_body0 (
		.st      (base_st),
		.take    (active && us.take0),
		.b       (us.byte0),
		.st_next (st0),
		.emit    (emit0)
	);

	ffcrc_body u_body1 (
		.st      (st0),
		.take    (active && us.take1),
		.b       (us.byte1),
		.st_next (st1),
		.emit    (emit1)
	);

	assign n_any = emit0 || emit1;
	assign n_two = emit0 && emit1;
	assign item0 = emit0 ? us.byte0 : us.byte1;
	assign item1 = us.byte1;

	assign lenp2 = {1'b0, st1.len} + 9'd2;
	assign lenp4 = {1'b0, st1.len} + 9'd4;
	assign end_count = (st1.count > lenp2) ? lenp2 : st1.count;

	always_comb begin
		if (st1.count != lenp4) begin
			end_kind = ffcrc_pkg::KIND_LEN_ERR;
		end else if (st1.crc == st1.rx_crc) begin
			end_kind = ffcrc_pkg::KIND_GOOD;
		end else begin
			end_kind = ffcrc_pkg::KIND_CRC_ERR;
		end
	end

	assign emit_any = close || (active && (hold_cur || n_any));
	assign res_data = close ? 8'h00 : (hold_cur ? hold_byte_q : item0);
	assign res_kind = close ? end_kind : ffcrc_pkg::KIND_PAYLOAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && rx_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			prev_ff_q    <= 1'b0;
			esc_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_byte_q  <= 8'h00;
			st_q         <= '0;
		end else if (step) begin
			if (!in_frame_q && is_flag) begin
				prev_ff_q <= 1'b1;
			end else if (active) begin
				st_q <= st1;
				if (close) begin
					in_frame_q   <= 1'b0;
					prev_ff_q    <= 1'b1;
					esc_q        <= 1'b0;
					hold_valid_q <= 1'b0;
				end else begin
					in_frame_q <= 1'b1;
					prev_ff_q  <= 1'b0;
					esc_q      <= us.esc_next;
					if (hold_cur) begin
						// held item leaves now, the newest item takes its place
						hold_valid_q <= n_any;
						hold_byte_q  <= item0;
					end else begin
						hold_valid_q <= n_two;
						hold_byte_q  <= item1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && emit_any;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit_any) begin
			data_q  <= res_data;
			kind_q  <= res_kind;
			count_q <= close ? end_count : 9'd0;
			end_q   <= close;
		end
	end

	assign res_valid     = res_valid_q;
	assign data_byte     = data_q;
	assign kind          = kind_q;
	assign payload_count = count_q;
	assign frame_end     = end_q;

	a_end_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> data_byte == 8'h00)
		else $error("end item carries nonzero data");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_end |-> kind == ffcrc_pkg::KIND_PAYLOAD && payload_count == 9'd0)
		else $error("payload item with end fields");

	a_good_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end && kind == ffcrc_pkg::KIND_GOOD |-> payload_count >= 9'd2)
		else $error("good frame with too few payload bytes");

	a_hold_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> in_frame_q)
		else $error("held payload byte outside a frame");

endmodule

[bench/tb.sv]
// testbench for the delimited frame crc checker: stuffed frames in, predicted result items checked
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [7:0]       data;
		ffcrc_pkg::kind_t verdict;
		logic [8:0]       count;
		logic             fend;
	} res_item_t;

	// tracks frame state on accepted bytes and holds the result items still owed
	class frame_scoreboard;
		res_item_t   pending_q[$];
		int          mismatches;
		logic        in_frame, prev_ff, esc_pend, hold_v;
		logic [7:0]  hold_b, len;
		logic [8:0]  body_cnt;
		logic [15:0] crc_acc, crc_rx;
		logic [7:0]  new_b[2];
		int          n_new;

		function new();
			mismatches = 0;
			in_frame = 1'b0;
			prev_ff = 1'b0;
			esc_pend = 1'b0;
			hold_v = 1'b0;
			hold_b = 8'h00;
			len = 8'h00;
			body_cnt = 9'd0;
			crc_acc = 16'h0000;
			crc_rx = 16'h0000;
		endfunction

		// reflected crc, one input bit at a time
		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c;
			for (int k = 0; k < 8; k++) begin
				if (r[0] ^ b[k]) begin
					r = (r >> 1) ^ ffcrc_pkg::CRC_POLY;
				end else begin
					r = r >> 1;
				end
			end
			return r;
		endfunction

		function void push(logic [7:0] d, ffcrc_pkg::kind_t v, logic [8:0] c, logic f);
			res_item_t e;
			e.data = d;
			e.verdict = v;
			e.count = c;
			e.fend = f;
			pending_q.push_back(e);
		endfunction

		function void take_body(logic [7:0] b);
			int idx, l;
			idx = body_cnt;
			l = len;
			if (body_cnt != ffcrc_pkg::COUNT_MAX) body_cnt++;
			if (idx < l + 2) begin
				if (idx == 1) len = b;
				crc_acc = crc_step(crc_acc, b);
				if (n_new < 2) begin
					new_b[n_new] = b;
					n_new++;
				end
			end else if (idx == l + 2) begin
				crc_rx[15:8] = b;
			end else if (idx == l + 3) begin
				crc_rx[7:0] = b;
			end
		endfunction

		function void note_rx_byte(logic [7:0] b);
			logic             closed;
			int               lim;
			ffcrc_pkg::kind_t v;
			n_new = 0;
			closed = 1'b0;
			if (!in_frame) begin
				if (b == ffcrc_pkg::FLAG_BYTE) begin
					prev_ff = 1'b1;
					return;
				end
				if (!prev_ff) return;
				in_frame = 1'b1;
				prev_ff = 1'b0;
				esc_pend = 1'b0;
				body_cnt = 9'd0;
				len = 8'h00;
				crc_acc = 16'h0000;
				crc_rx = 16'h0000;
				hold_v = 1'b0;
			end
			if (b == ffcrc_pkg::FLAG_BYTE) begin
				// a dangling escape reads as a literal byte
				if (esc_pend) take_body(ffcrc_pkg::ESC_BYTE);
				closed = 1'b1;
			end else if (esc_pend) begin
				if (b == ffcrc_pkg::ESC_ZERO) begin
					take_body(ffcrc_pkg::ESC_BYTE);
					esc_pend = 1'b0;
				end else if (b == ffcrc_pkg::ESC_ONE) begin
					take_body(ffcrc_pkg::FLAG_BYTE);
					esc_pend = 1'b0;
				end else if (b == ffcrc_pkg::ESC_BYTE) begin
					take_body(ffcrc_pkg::ESC_BYTE);
				end else begin
					take_body(ffcrc_pkg::ESC_BYTE);
					take_body(b);
					esc_pend = 1'b0;
				end
			end else if (b == ffcrc_pkg::ESC_BYTE) begin
				esc_pend = 1'b1;
			end else begin
				take_body(b);
			end

			if (closed) begin
				lim = int'(len) + 2;
				if (int'(body_cnt) != lim + 2) v = ffcrc_pkg::KIND_LEN_ERR;
				else if (crc_acc == crc_rx) v = ffcrc_pkg::KIND_GOOD;
				else v = ffcrc_pkg::KIND_CRC_ERR;
				push(8'h00, v, (int'(body_cnt) > lim) ? 9'(lim) : body_cnt, 1'b1);
				// a held byte is dropped at close
				hold_v = 1'b0;
				in_frame = 1'b0;
				prev_ff = 1'b1;
				esc_pend = 1'b0;
			end else if (hold_v) begin
				push(hold_b, ffcrc_pkg::KIND_PAYLOAD, 9'd0, 1'b0);
				hold_v = (n_new > 0);
				hold_b = new_b[0];
			end else if (n_new > 0) begin
				push(new_b[0], ffcrc_pkg::KIND_PAYLOAD, 9'd0, 1'b0);
				if (n_new > 1) begin
					hold_v = 1'b1;
					hold_b = new_b[1];
				end
			end
		endfunction

		function void check_res(logic [7:0] d, logic [1:0] k, logic [8:0] c, logic f);
			res_item_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: data %02h kind %0d count %0d end %0b",
						d, k, c, f);
				return;
			end
			e = pending_q.pop_front();
			if (d !== e.data || k !== e.verdict || c !== e.count || f !== e.fend) begin
				mismatches++;
				if (mismatches <= 10)
					$display(
						"mismatch data/kind/count/end: exp %02h/%0d/%0d/%0b got %02h/%0d/%0d/%0b",
						e.data, e.verdict, e.count, e.fend, d, k, c, f);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_ready;
	logic [7:0] rx_byte;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] data_byte;
	logic [1:0] kind;
	logic [8:0] payload_count;
	logic       frame_end;

	frame_scoreboard sb;
	int              idle_pct;
	int              stall_pct;
	int              bytes_sent;
	logic [7:0]      body_q[$];
	logic [7:0]      line_q[$];

	ff_delimited_frame_crc_checker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_ready      (rx_ready),
		.rx_byte       (rx_byte),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.data_byte     (data_byte),
		.kind          (kind),
		.payload_count (payload_count),
		.frame_end     (frame_end)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_res(data_byte, kind, payload_count, frame_end);
	end

	initial begin
		#5_000_000;
		$display("[ff_delimited_frame_crc_checker_top] ERROR");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		sb.note_rx_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_byte(line_q[i]);
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_body_byte();
		case ($urandom_range(7))
			0: return ffcrc_pkg::ESC_BYTE;
			1: return ffcrc_pkg::FLAG_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// append crc over frame number, length and data
	task automatic seal_body();
		logic [15:0] c;
		c = 16'h0000;
		foreach (body_q[i]) c = frame_scoreboard::crc_step(c, body_q[i]);
		body_q.push_back(c[15:8]);
		body_q.push_back(c[7:0]);
	endtask

	task automatic build_body(input int l);
		body_q.delete();
		body_q.push_back(rand_body_byte());
		body_q.push_back(8'(l));
		repeat (l) body_q.push_back(rand_body_byte());
		seal_body();
	endtask

	// body_q -> line_q with escapes, sometimes leaving a bare escape where it reads literal
	task automatic stuff_body();
		logic [7:0] nxt;
		line_q.delete();
		for (int i = 0; i < body_q.size(); i++) begin
			if (body_q[i] == ffcrc_pkg::FLAG_BYTE) begin
				line_q.push_back(ffcrc_pkg::ESC_BYTE);
				line_q.push_back(ffcrc_pkg::ESC_ONE);
			end else if (body_q[i] == ffcrc_pkg::ESC_BYTE) begin
				nxt = (i + 1 < body_q.size()) ? body_q[i + 1] : ffcrc_pkg::FLAG_BYTE;
				line_q.push_back(ffcrc_pkg::ESC_BYTE);
				if (nxt == ffcrc_pkg::ESC_ZERO || nxt == ffcrc_pkg::ESC_ONE || $urandom_range(1))
					line_q.push_back(ffcrc_pkg::ESC_ZERO);
			end else begin
				line_q.push_back(body_q[i]);
			end
		end
	endtask

	task automatic send_random_frame();
		int pick, l, i;
		pick = $urandom_range(99);
		l = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
		build_body(l);
		if (pick < 12) begin
			// single bit error past the length byte
			i = $urandom_range(body_q.size() - 1, 2);
			body_q[i] = body_q[i] ^ (8'h01 << $urandom_range(7));
		end else if (pick < 24) begin
			repeat ($urandom_range(body_q.size(), 1)) void'(body_q.pop_back());
		end else if (pick < 32) begin
			repeat ($urandom_range(3, 1)) body_q.push_back(rand_body_byte());
		end
		stuff_body();
		if (pick >= 32 && pick < 40) begin
			// raw line noise, may hold flags and odd escapes
			line_q.delete();
			repeat ($urandom_range(12, 1)) begin
				if ($urandom_range(9) == 0) line_q.push_back(ffcrc_pkg::FLAG_BYTE);
				else if ($urandom_range(4) == 0) line_q.push_back(ffcrc_pkg::ESC_BYTE);
				else line_q.push_back(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(3) == 0) line_q.push_front(ffcrc_pkg::FLAG_BYTE);
		line_q.push_back(ffcrc_pkg::FLAG_BYTE);
		send_line();
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		int target;
		idle_tab = '{0, 48, 0, 13};
		stall_tab = '{0, 0, 48, 13};
		sb = new();
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bytes before any flag are ignored
		send_byte(8'h12);
		send_byte(8'h00);
		// frame number and data needing escapes
		body_q = '{ffcrc_pkg::FLAG_BYTE, 8'h01, ffcrc_pkg::ESC_BYTE};
		seal_body();
		stuff_body();
		line_q.push_front(ffcrc_pkg::FLAG_BYTE);
		line_q.push_back(ffcrc_pkg::FLAG_BYTE);
		send_line();
		// literal escape, escape after escape, escape pending at close
		line_q = '{ffcrc_pkg::ESC_BYTE, 8'h41, ffcrc_pkg::ESC_BYTE, ffcrc_pkg::ESC_BYTE,
			ffcrc_pkg::ESC_ZERO, ffcrc_pkg::ESC_BYTE, ffcrc_pkg::FLAG_BYTE};
		send_line();
		// one body byte only, judged against a cleared length
		line_q = '{8'h05, ffcrc_pkg::FLAG_BYTE};
		send_line();
		drain();

		// longest declared length with a tail long enough to saturate the count
		build_body(255);
		repeat (256) body_q.push_back(rand_body_byte());
		stuff_body();
		line_q.push_back(ffcrc_pkg::FLAG_BYTE);
		send_line();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			target = bytes_sent + 100;
			while (bytes_sent < target) begin
				send_random_frame();
				if ($urandom_range(15) == 0) drain();
			end
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		drain();
		repeat (8) @(posedge clk);
		if (sb.pending_q.size() != 0)
			$display("%0d expected result items never arrived", sb.pending_q.size());
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("[ff_delimited_frame_crc_checker_top] OK");
		end else begin
			$display("[ff_delimited_frame_crc_checker_top] ERROR");
		end
		$finish;
	end

endmodule
